/* design/b32d_pkg.sv */
// ---------------------------------------------------------------------------
// b32d_pkg - shared types and helpers of the base32 stream decoder
// Character tables, status codes and the job word passed from front to back.
// ---------------------------------------------------------------------------
package b32d_pkg;

    localparam int DEFAULT_POSITION_WIDTH = 20;
    localparam int DEFAULT_QUEUE_DEPTH    = 4;

    localparam int ACC_W       = 40;
    localparam int GROUP_BYTES = 5;

    localparam logic [7:0] CHAR_PAD  = 8'h3D;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] BAD_VALUE = 8'hFF;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_PADDING = 2'd2,
        ST_ILLEGAL = 2'd3
    } status_t;

    // one job: up to five bytes (left aligned) and optionally the status word
    typedef struct packed {
        logic [ACC_W-1:0] data;
        logic [2:0]       nbytes;
        logic             fin;
        status_t          status;
        logic [7:0]       code;
    } job_t;

    function automatic logic [7:0] rfc_value(input logic [7:0] c);
        logic [7:0] v;
        v = BAD_VALUE;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61;
        end else if (c >= 8'h32 && c <= 8'h37) begin
            v = c - 8'h32 + 8'd26;
        end
        return v;
    endfunction

    function automatic logic [7:0] crock_letter(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:  v = 8'd10;
            5'd1:  v = 8'd11;
            5'd2:  v = 8'd12;
            5'd3:  v = 8'd13;
            5'd4:  v = 8'd14;
            5'd5:  v = 8'd15;
            5'd6:  v = 8'd16;
            5'd7:  v = 8'd17;
            5'd8:  v = 8'd1;
            5'd9:  v = 8'd18;
            5'd10: v = 8'd19;
            5'd11: v = 8'd1;
            5'd12: v = 8'd20;
            5'd13: v = 8'd21;
            5'd14: v = 8'd0;
            5'd15: v = 8'd22;
            5'd16: v = 8'd23;
            5'd17: v = 8'd24;
            5'd18: v = 8'd25;
            5'd19: v = 8'd26;
            5'd20: v = BAD_VALUE;
            5'd21: v = 8'd27;
            5'd22: v = 8'd28;
            5'd23: v = 8'd29;
            5'd24: v = 8'd30;
            5'd25: v = 8'd31;
            default: v = BAD_VALUE;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] crock_value(input logic [7:0] c);
        logic [7:0] v;
        logic [7:0] off;
        v   = BAD_VALUE;
        off = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            off = c - 8'h41;
            v   = crock_letter(off[4:0]);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            off = c - 8'h61;
            v   = crock_letter(off[4:0]);
        end
        return v;
    endfunction

endpackage

/* design/b32d_queue.sv */
// ---------------------------------------------------------------------------
// b32d_queue - short job queue
// Register based first-in first-out buffer between the front and back parts.
// ---------------------------------------------------------------------------
module b32d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

endmodule

/* design/b32d_front.sv */
// ---------------------------------------------------------------------------
// b32d_front - character intake and classification
// Decodes each character, tracks padding, length and errors, and packs
// completed groups, flushes and end status into jobs.
// ---------------------------------------------------------------------------
module b32d_front #(
    parameter int POSITION_WIDTH = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_char_code,
    input  logic                      s_final_char,
    input  logic                      queue_full,
    output logic                      job_push,
    output b32d_pkg::job_t            job,
    output logic [POSITION_WIDTH-1:0] job_pos
);
    import b32d_pkg::*;

    logic                      mode_reg;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [2:0]                phase_reg, phase_next;
    logic [2:0]                pad_len_reg, pad_len_next;
    logic [POSITION_WIDTH-1:0] pad_start_reg, pad_start_next;
    logic                      ill_reg, ill_next;
    logic [POSITION_WIDTH-1:0] ill_pos_reg, ill_pos_next;
    logic [7:0]                ill_code_reg, ill_code_next;

    logic             take;
    logic [7:0]       val;
    logic             group;
    logic [ACC_W-1:0] acc_v;
    logic [5:0]       cnt_v;
    logic [5:0]       shift;
    status_t          status;
    logic             accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next       = (pos_reg != '1) ? pos_reg + POSITION_WIDTH'(1) : pos_reg;
        phase_next     = phase_reg + 3'd1;
        pad_len_next   = pad_len_reg;
        pad_start_next = pad_start_reg;
        ill_next       = ill_reg;
        ill_pos_next   = ill_pos_reg;
        ill_code_next  = ill_code_reg;
        acc_v          = acc_reg;
        cnt_v          = cnt_reg;
        take           = 1'b0;
        val            = BAD_VALUE;
        group          = 1'b0;

        if (!mode_reg) begin
            if (s_char_code == CHAR_PAD) begin
                if (pad_len_reg == 3'd0) begin
                    pad_start_next = pos_next;
                end
                if (pad_len_reg != 3'd7) begin
                    pad_len_next = pad_len_reg + 3'd1;
                end
            end else begin
                // interrupted pad run: the run's first pad is the culprit
                if (pad_len_reg != 3'd0) begin
                    if (!ill_next) begin
                        ill_next      = 1'b1;
                        ill_pos_next  = pad_start_reg;
                        ill_code_next = CHAR_PAD;
                    end
                    pad_len_next = 3'd0;
                end
                take = 1'b1;
                val  = rfc_value(s_char_code);
            end
        end else if (s_char_code != CHAR_DASH) begin
            take = 1'b1;
            val  = crock_value(s_char_code);
        end

        if (take) begin
            if (val == BAD_VALUE) begin
                if (!ill_next) begin
                    ill_next      = 1'b1;
                    ill_pos_next  = pos_next;
                    ill_code_next = s_char_code;
                end
            end else if (!ill_next) begin
                acc_v = {acc_reg[ACC_W-6:0], val[4:0]};
                cnt_v = cnt_reg + 6'd5;
                group = (cnt_v == 6'(ACC_W));
            end
        end

        status = ST_OK;
        if (s_final_char) begin
            if (!mode_reg && phase_next != 3'd0) begin
                status = ST_LENGTH;
            end else if (!mode_reg && (pad_len_next == 3'd2 || pad_len_next == 3'd5 ||
                                       pad_len_next == 3'd7)) begin
                status = ST_PADDING;
            end else if (ill_next) begin
                status = ST_ILLEGAL;
            end
        end

        acc_next = group ? '0 : acc_v;
        cnt_next = group ? '0 : cnt_v;

        shift       = 6'(ACC_W) - cnt_v;
        job.data    = acc_v;
        job.nbytes  = 3'd0;
        job.fin     = s_final_char;
        job.status  = status;
        job.code    = (status == ST_ILLEGAL) ? ill_code_next : 8'd0;
        job_pos     = (status == ST_ILLEGAL) ? ill_pos_next : '0;
        if (group) begin
            if (!s_final_char || status == ST_OK) begin
                job.nbytes = 3'(GROUP_BYTES);
            end
        end else if (s_final_char && status == ST_OK && !ill_next) begin
            // left align the remaining bits, whole bytes only
            job.data   = acc_v << shift;
            job.nbytes = cnt_v[5:3];
        end

        job_push = accept && (job.nbytes != 3'd0 || s_final_char);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            phase_reg     <= '0;
            pad_len_reg   <= '0;
            pad_start_reg <= '0;
            ill_reg       <= 1'b0;
            ill_pos_reg   <= '0;
            ill_code_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (accept) begin
                if (s_final_char) begin
                    acc_reg       <= '0;
                    cnt_reg       <= '0;
                    pos_reg       <= '0;
                    phase_reg     <= '0;
                    pad_len_reg   <= '0;
                    pad_start_reg <= '0;
                    ill_reg       <= 1'b0;
                    ill_pos_reg   <= '0;
                    ill_code_reg  <= '0;
                end else begin
                    acc_reg       <= acc_next;
                    cnt_reg       <= cnt_next;
                    pos_reg       <= pos_next;
                    phase_reg     <= phase_next;
                    pad_len_reg   <= pad_len_next;
                    pad_start_reg <= pad_start_next;
                    ill_reg       <= ill_next;
                    ill_pos_reg   <= ill_pos_next;
                    ill_code_reg  <= ill_code_next;
                end
            end
        end
    end

endmodule

/* design/b32d_back.sv */
// ---------------------------------------------------------------------------
// b32d_back - result sequencer
// Walks the head job byte by byte, then, for a job that ends a string, its
// status word, into an output register.
// ---------------------------------------------------------------------------
module b32d_back #(
    parameter int POSITION_WIDTH = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      head_valid,
    input  b32d_pkg::job_t            head,
    input  logic [POSITION_WIDTH-1:0] head_pos,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_item_kind,
    output logic [7:0]                m_data_byte,
    output logic [1:0]                m_status_code,
    output logic [POSITION_WIDTH-1:0] m_error_position,
    output logic [7:0]                m_error_char,
    output logic                      m_last_result
);
    import b32d_pkg::*;

    logic [2:0]                idx_reg;
    logic                      m_valid_reg;
    logic                      kind_reg;
    logic [7:0]                byte_reg;
    logic [1:0]                status_reg;
    logic [POSITION_WIDTH-1:0] epos_reg;
    logic [7:0]                echar_reg;
    logic                      last_reg;

    logic       load;
    logic       is_data;
    logic       last_item;
    logic [7:0] sel_byte;

    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign is_data = (idx_reg < head.nbytes);
    assign last_item = head.fin ? (idx_reg == head.nbytes)
                                : (idx_reg == head.nbytes - 3'd1);
    assign pop     = load && last_item;

    always_comb begin
        unique case (idx_reg)
            3'd0:    sel_byte = head.data[39:32];
            3'd1:    sel_byte = head.data[31:24];
            3'd2:    sel_byte = head.data[23:16];
            3'd3:    sel_byte = head.data[15:8];
            3'd4:    sel_byte = head.data[7:0];
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last_item ? 3'd0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (is_data) begin
                kind_reg   <= KIND_DATA;
                byte_reg   <= sel_byte;
                status_reg <= ST_OK;
                epos_reg   <= '0;
                echar_reg  <= 8'd0;
                last_reg   <= 1'b0;
            end else begin
                kind_reg   <= KIND_STATUS;
                byte_reg   <= 8'd0;
                status_reg <= head.status;
                epos_reg   <= head_pos;
                echar_reg  <= head.code;
                last_reg   <= 1'b1;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_item_kind      = kind_reg;
    assign m_data_byte      = byte_reg;
    assign m_status_code    = status_reg;
    assign m_error_position = epos_reg;
    assign m_error_char     = echar_reg;
    assign m_last_result    = last_reg;

endmodule

/* design/base32_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// base32_stream_decoder_unit - streaming base32 decoder
// RFC 4648 or Crockford alphabet, bytes out most significant first, one
// status word after the last character of each string.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    char_code, final_char
//  m_*       out        m_valid / m_ready    kind, byte, status, position, char
//  cfg_*     in         cfg_valid/cfg_ready  alphabet mode bit
//
// one character a cycle while the job queue has room; a character makes at
// most one job of up to six output words, drained at one word a cycle while m_ready is high
// the first word of a job passes through the queue, then the output register
// synchronous active-low reset clears string state, mode and queue
// a stalled output fills the queue, which then drops s_ready
// ---------------------------------------------------------------------------
module base32_stream_decoder_unit #(
    parameter int POSITION_WIDTH = b32d_pkg::DEFAULT_POSITION_WIDTH,
    parameter int QUEUE_DEPTH    = b32d_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_char_code,
    input  logic                      s_final_char,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_item_kind,
    output logic [7:0]                m_data_byte,
    output logic [1:0]                m_status_code,
    output logic [POSITION_WIDTH-1:0] m_error_position,
    output logic [7:0]                m_error_char,
    output logic                      m_last_result
);
    import b32d_pkg::*;

    localparam int JOB_W = $bits(job_t);
    localparam int Q_W   = JOB_W + POSITION_WIDTH;

    logic                      queue_full;
    logic                      job_push;
    job_t                      job;
    logic [POSITION_WIDTH-1:0] job_pos;
    logic                      head_valid;
    logic [Q_W-1:0]            head_word;
    job_t                      head;
    logic [POSITION_WIDTH-1:0] head_pos;
    logic                      pop;

    assign cfg_ready = 1'b1;

    b32d_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_final_char(s_final_char),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (job),
        .job_pos     (job_pos)
    );

    b32d_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data ({job, job_pos}),
        .full      (queue_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_data (head_word)
    );

    assign head     = head_word[Q_W-1:POSITION_WIDTH];
    assign head_pos = head_word[POSITION_WIDTH-1:0];

    b32d_back #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head            (head),
        .head_pos        (head_pos),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_data_byte     (m_data_byte),
        .m_status_code   (m_status_code),
        .m_error_position(m_error_position),
        .m_error_char    (m_error_char),
        .m_last_result   (m_last_result)
    );

endmodule
